// ===== sv/ptad_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the port table allocator and datagram demultiplexer.
// No dependencies; every other file of the block imports this package.
package ptad_pkg;

   // Operation codes carried by req_func.
   localparam logic [1:0] FUNC_OPEN     = 2'd0;
   localparam logic [1:0] FUNC_ALLOC    = 2'd1;
   localparam logic [1:0] FUNC_FREE     = 2'd2;
   localparam logic [1:0] FUNC_CLASSIFY = 2'd3;

   // Entry kinds held in the port table.
   localparam logic [1:0] KIND_EMPTY  = 2'd0;
   localparam logic [1:0] KIND_LISTEN = 2'd1;
   localparam logic [1:0] KIND_SEND   = 2'd2;

   // Result status codes.
   localparam logic [3:0] STATUS_CREATED      = 4'd0;
   localparam logic [3:0] STATUS_ALREADY_OPEN = 4'd1;
   localparam logic [3:0] STATUS_OUT_OF_RANGE = 4'd2;
   localparam logic [3:0] STATUS_FULL         = 4'd3;
   localparam logic [3:0] STATUS_FREED        = 4'd4;
   localparam logic [3:0] STATUS_FREE_IGNORED = 4'd5;
   localparam logic [3:0] STATUS_DELIVERED    = 4'd6;
   localparam logic [3:0] STATUS_BAD_PROTOCOL = 4'd7;
   localparam logic [3:0] STATUS_BAD_RANGE    = 4'd8;
   localparam logic [3:0] STATUS_NO_LISTENER  = 4'd9;
   localparam logic [3:0] STATUS_STREAM_DROP  = 4'd10;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LOCAL_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_DATAGRAM_CODE = 2'd1;
   localparam logic [1:0] CSR_STREAM_CODE   = 2'd2;

   localparam logic [7:0] DATAGRAM_CODE_RESET = 8'd1;
   localparam logic [7:0] STREAM_CODE_RESET   = 8'd2;

   typedef enum logic [1:0] {
      PTAD_CLEAR,
      PTAD_IDLE,
      PTAD_EXEC
   } ptad_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;   // write one empty entry of the clearing pass
      logic issue;   // capture a transaction and read its first table entry
      logic step;    // advance the allocation search by one entry
      logic finish;  // commit the table write and load the result register
   } ptad_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_more;
      logic clear_last;
   } ptad_stat_type;

endpackage

// ===== sv/ptad_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: clearing pass, transaction capture, execution and
// the result valid flag. Depends on ptad_pkg.
module ptad_ctrl
   import ptad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  ptad_stat_type stat,
   output ptad_cmd_type  cmd
);

   ptad_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         PTAD_CLEAR: begin
            cmd.clear = 1'b1;
         end
         PTAD_IDLE: begin
            req_ready = 1'b1;
            cmd.issue = req_valid;
         end
         PTAD_EXEC: begin
            // The result register must be free, or emptied this cycle, to finish.
            if (stat.search_more) begin
               cmd.step = 1'b1;
            end else begin
               cmd.finish = !rsp_valid_ff || rsp_ready;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PTAD_CLEAR: begin
            if (stat.clear_last) state_in = PTAD_IDLE;
         end
         PTAD_IDLE: begin
            if (cmd.issue) state_in = PTAD_EXEC;
         end
         PTAD_EXEC: begin
            if (cmd.finish) state_in = PTAD_IDLE;
         end
         default: begin
            state_in = PTAD_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PTAD_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/ptad_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: port table memory, configuration registers, operation decode,
// allocation search pointer and the result register. Depends on ptad_pkg.
module ptad_dpath
   import ptad_pkg::*;
#(
   parameter int PORT_COUNT   = 65536,
   parameter int SENDING_BASE = 32768,
   parameter int ADDRESS_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  ptad_cmd_type  cmd,
   output ptad_stat_type stat,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_wdata,
   input  logic [1:0]    req_func,
   input  logic [15:0]   req_port,
   input  logic [7:0]    req_protocol_byte,
   input  logic [63:0]   req_dest_address,
   input  logic [15:0]   req_source_port,
   input  logic [15:0]   req_dest_port,
   output logic [3:0]    rsp_status,
   output logic [15:0]   rsp_result_port
);

   localparam int          IDX_W  = $clog2(PORT_COUNT);
   localparam logic [16:0] PC_L   = 17'(PORT_COUNT);
   localparam logic [16:0] SB_L   = 17'(SENDING_BASE);
   localparam logic [16:0] SPAN_L = (SENDING_BASE < PORT_COUNT) ?
                                    17'(PORT_COUNT - SENDING_BASE) : 17'd0;

   // Next port of the sending range, wrapping from the top back to the base.
   function automatic logic [15:0] wrap_next(input logic [15:0] p);
      logic [16:0] q;
      q = {1'b0, p} + 17'd1;
      return (q >= PC_L) ? SB_L[15:0] : q[15:0];
   endfunction

   logic [1:0] kind_mem [PORT_COUNT];
   logic [1:0] kind_rd_ff;

   logic [ADDRESS_BITS-1:0] local_address_ff;
   logic [7:0]              datagram_code_ff;
   logic [7:0]              stream_code_ff;

   logic [1:0]              func_ff;
   logic [15:0]             port_ff;
   logic [7:0]              proto_ff;
   logic [ADDRESS_BITS-1:0] daddr_ff;
   logic [15:0]             sport_ff;
   logic [15:0]             dport_ff;

   logic [15:0]      search_ff;
   logic [16:0]      cnt_ff;
   logic [15:0]      next_port_ff;
   logic [IDX_W-1:0] clr_cnt_ff;
   logic [3:0]       status_ff;
   logic [15:0]      result_port_ff;

   logic [15:0]      start_port;
   logic [15:0]      search_next;
   logic [15:0]      rd_port;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [1:0]       wr_kind;
   logic             mem_we;
   logic             mem_re;

   logic [3:0]  dec_status;
   logic [15:0] dec_port;
   logic        dec_we;
   logic [1:0]  dec_kind;
   logic        alloc_hit;
   logic        search_more;
   logic        exhausted;

   assign start_port  = ({1'b0, next_port_ff} < SB_L || {1'b0, next_port_ff} >= PC_L) ?
                        SB_L[15:0] : next_port_ff;
   assign search_next = wrap_next(search_ff);

   always_comb begin
      if (cmd.step) begin
         rd_port = search_next;
      end else begin
         unique case (req_func)
            FUNC_ALLOC:    rd_port = start_port;
            FUNC_CLASSIFY: rd_port = req_dest_port;
            default:       rd_port = req_port;
         endcase
      end
   end

   assign rd_addr = rd_port[IDX_W-1:0];
   assign mem_re  = cmd.issue | cmd.step;

   // Entries checked so far include the one now in kind_rd_ff.
   assign exhausted = (cnt_ff + 17'd1) >= SPAN_L;

   always_comb begin
      dec_status  = STATUS_BAD_PROTOCOL;
      dec_port    = 16'd0;
      dec_we      = 1'b0;
      dec_kind    = KIND_EMPTY;
      alloc_hit   = 1'b0;
      search_more = 1'b0;
      unique case (func_ff)
         FUNC_OPEN: begin
            if ({1'b0, port_ff} >= SB_L || {1'b0, port_ff} >= PC_L) begin
               dec_status = STATUS_OUT_OF_RANGE;
            end else if (kind_rd_ff != KIND_EMPTY) begin
               dec_status = STATUS_ALREADY_OPEN;
               dec_port   = port_ff;
            end else begin
               dec_status = STATUS_CREATED;
               dec_port   = port_ff;
               dec_we     = 1'b1;
               dec_kind   = KIND_LISTEN;
            end
         end
         FUNC_ALLOC: begin
            if (SPAN_L == 17'd0) begin
               dec_status = STATUS_FULL;
            end else if (kind_rd_ff == KIND_EMPTY) begin
               dec_status = STATUS_CREATED;
               dec_port   = search_ff;
               dec_we     = 1'b1;
               dec_kind   = KIND_SEND;
               alloc_hit  = 1'b1;
            end else if (exhausted) begin
               dec_status = STATUS_FULL;
            end else begin
               search_more = 1'b1;
            end
         end
         FUNC_FREE: begin
            if ({1'b0, port_ff} >= PC_L || kind_rd_ff == KIND_EMPTY) begin
               dec_status = STATUS_FREE_IGNORED;
            end else begin
               dec_status = STATUS_FREED;
               dec_port   = port_ff;
               dec_we     = 1'b1;
               dec_kind   = KIND_EMPTY;
            end
         end
         FUNC_CLASSIFY: begin
            // The datagram meaning wins when both protocol codes are equal.
            priority if (proto_ff == datagram_code_ff) begin
               if (daddr_ff != local_address_ff || {1'b0, sport_ff} >= SB_L ||
                   {1'b0, dport_ff} >= SB_L || {1'b0, dport_ff} >= PC_L) begin
                  dec_status = STATUS_BAD_RANGE;
               end else if (kind_rd_ff != KIND_LISTEN) begin
                  dec_status = STATUS_NO_LISTENER;
               end else begin
                  dec_status = STATUS_DELIVERED;
                  dec_port   = dport_ff;
               end
            end else if (proto_ff == stream_code_ff) begin
               dec_status = STATUS_STREAM_DROP;
            end else begin
               dec_status = STATUS_BAD_PROTOCOL;
            end
         end
         default: begin
            dec_status = STATUS_BAD_PROTOCOL;
         end
      endcase
   end

   assign mem_we  = cmd.clear | (cmd.finish & dec_we);
   assign wr_addr = cmd.clear ? clr_cnt_ff :
                    (func_ff == FUNC_ALLOC) ? search_ff[IDX_W-1:0] : port_ff[IDX_W-1:0];
   assign wr_kind = cmd.clear ? KIND_EMPTY : dec_kind;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         kind_mem[wr_addr] <= wr_kind;
      end
      if (mem_re) begin
         kind_rd_ff <= kind_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
         datagram_code_ff <= DATAGRAM_CODE_RESET;
         stream_code_ff   <= STREAM_CODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCAL_ADDRESS: local_address_ff <= csr_wdata[ADDRESS_BITS-1:0];
            CSR_DATAGRAM_CODE: datagram_code_ff <= csr_wdata[7:0];
            CSR_STREAM_CODE:   stream_code_ff   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_port_ff <= SB_L[15:0];
         clr_cnt_ff   <= '0;
      end else begin
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.finish && alloc_hit) next_port_ff <= search_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         func_ff   <= req_func;
         port_ff   <= req_port;
         proto_ff  <= req_protocol_byte;
         daddr_ff  <= req_dest_address[ADDRESS_BITS-1:0];
         sport_ff  <= req_source_port;
         dport_ff  <= req_dest_port;
         search_ff <= start_port;
         cnt_ff    <= 17'd0;
      end else if (cmd.step) begin
         search_ff <= search_next;
         cnt_ff    <= cnt_ff + 17'd1;
      end
      if (cmd.finish) begin
         status_ff      <= dec_status;
         result_port_ff <= dec_port;
      end
   end

   assign stat.search_more = search_more;
   assign stat.clear_last  = (clr_cnt_ff == IDX_W'(PORT_COUNT - 1));
   assign rsp_status       = status_ff;
   assign rsp_result_port  = result_port_ff;

endmodule

// ===== sv/port_table_allocator_demux_unit.sv =====
`timescale 1ns / 1ps
// Top level of the port table allocator and datagram demultiplexer.
// Depends on ptad_pkg, ptad_ctrl and ptad_dpath.

// After reset the block sweeps the port table, one entry per cycle, with
// req_ready low; configuration writes are taken during that pass.
// Transactions are handled one at a time on a single-port table.
// Open, free and classify read the table entry in the cycle of acceptance;
// in the execution state the entry is then evaluated, the table written and
// the result register loaded. Allocation examines table entries with a
// rotating search, at most PORT_COUNT - SENDING_BASE of them; the table
// gives one entry per cycle. A new transaction is accepted while the
// previous result still waits on rsp_ready, but its final cycle is held
// until that previous result has been taken.
module port_table_allocator_demux_unit
   import ptad_pkg::*;
#(
   parameter int PORT_COUNT   = 65536,
   parameter int SENDING_BASE = 32768,
   parameter int ADDRESS_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_port,
   input  logic [7:0]  req_protocol_byte,
   input  logic [63:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_result_port
);

   ptad_cmd_type  cmd;
   ptad_stat_type stat;

   ptad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptad_dpath #(
      .PORT_COUNT   (PORT_COUNT),
      .SENDING_BASE (SENDING_BASE),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_func          (req_func),
      .req_port          (req_port),
      .req_protocol_byte (req_protocol_byte),
      .req_dest_address  (req_dest_address),
      .req_source_port   (req_source_port),
      .req_dest_port     (req_dest_port),
      .rsp_status        (rsp_status),
      .rsp_result_port   (rsp_result_port)
   );

endmodule

// ===== sv/ptad_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for port_table_allocator_demux_unit, attached by bind.
// Depends on ptad_pkg for the status codes.
module ptad_chk
   import ptad_pkg::*;
#(
   parameter int PORT_COUNT = 65536
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_status,
   input logic [15:0] rsp_result_port
);

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_result_port))
      else $error("result changed while stalled");

   // One transaction is in work at a time, so ready drops after an acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted while another is in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_STREAM_DROP)
      else $error("undefined status code");

   // Failing outcomes carry no port.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OUT_OF_RANGE || rsp_status == STATUS_FULL ||
                    rsp_status == STATUS_FREE_IGNORED || rsp_status == STATUS_BAD_PROTOCOL ||
                    rsp_status == STATUS_BAD_RANGE || rsp_status == STATUS_NO_LISTENER ||
                    rsp_status == STATUS_STREAM_DROP)
      |-> rsp_result_port == 16'd0)
      else $error("failing status with nonzero port");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_result_port} < 17'(PORT_COUNT))
      else $error("result port outside the table");

endmodule

bind port_table_allocator_demux_unit ptad_chk #(.PORT_COUNT(PORT_COUNT)) u_ptad_chk (.*);
